FILE: rtl/core/rgbhsl_pkg.sv
// ----------------------------------------------------------------------------
// rgbhsl_pkg
// Shared types, constants and datapath functions of the RGB to HSL core.
// ----------------------------------------------------------------------------
package rgbhsl_pkg;

  localparam int ChanW      = 8;   // input channel width
  localparam int OutW       = 16;  // hue / saturation / lightness width
  localparam int SumW       = ChanW + 1;
  localparam int HueDivW    = 11;  // 6 * chroma, up to 1530
  localparam int SatDivW    = ChanW;
  localparam int NumW       = 13;  // signed hue numerator before wrap
  localparam int DivStages  = 8;   // quotient stages
  localparam int BitsPerStg = OutW / DivStages;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

  // After the min/max stage.
  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    sector_t          sector;
    logic [ChanW-1:0] chroma;
    logic [SumW-1:0]  sum;
  } mm_t;

  // One quotient stage of both dividers plus the lightness passenger.
  typedef struct packed {
    logic [HueDivW-1:0] hue_rem;
    logic [HueDivW-1:0] hue_div;
    logic [OutW-1:0]    hue_q;
    logic [SatDivW-1:0] sat_rem;
    logic [SatDivW-1:0] sat_div;
    logic [OutW-1:0]    sat_low;
    logic [OutW-1:0]    sat_q;
    logic [OutW-1:0]    light;
  } div_t;

  // Restoring division, BitsPerStg quotient bits for each divider.
  function automatic div_t div_step(input div_t x);
    div_t               y;
    logic [HueDivW:0]   hr;
    logic [SatDivW:0]   sr;
    y = x;
    for (int i = 0; i < BitsPerStg; i++) begin
      hr = {y.hue_rem, 1'b0};
      if (hr >= {1'b0, y.hue_div}) begin
        hr        = hr - {1'b0, y.hue_div};
        y.hue_q   = {y.hue_q[OutW-2:0], 1'b1};
      end else begin
        y.hue_q   = {y.hue_q[OutW-2:0], 1'b0};
      end
      y.hue_rem = hr[HueDivW-1:0];

      sr = {y.sat_rem, y.sat_low[OutW-1]};
      y.sat_low = {y.sat_low[OutW-2:0], 1'b0};
      if (sr >= {1'b0, y.sat_div}) begin
        sr      = sr - {1'b0, y.sat_div};
        y.sat_q = {y.sat_q[OutW-2:0], 1'b1};
      end else begin
        y.sat_q = {y.sat_q[OutW-2:0], 1'b0};
      end
      y.sat_rem = sr[SatDivW-1:0];
    end
    return y;
  endfunction

endpackage

FILE: rtl/core/rgb_to_hsl_converter_core.sv
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter_core
// Pipelined RGB to HSL conversion, one pixel per clock unless held by out_stall.
// ----------------------------------------------------------------------------
//
//   channel  ports                                   direction  beat
//   -------  --------------------------------------  ---------  -----------------
//   in       in_valid in_stall in_red/green/blue     sink       one RGB pixel
//   out      out_valid out_stall out_hue/sat/light   source     one HSL result
//
// The pipeline has a min/max stage, a setup stage (hue numerator, divisors,
// lightness) and eight quotient stages retiring two bits of each divider.
// Throughput is one beat per cycle; every stage holds only while the stage
// after it is full and holding, so bubbles are squeezed out under stall.
// A stall on the output reaches in_stall only once all ten stages are full.
// Reset (rst_n, synchronous) clears the valid bits only; payload is not reset.
//
module rgb_to_hsl_converter_core
  import rgbhsl_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,

  input  logic            in_valid,
  output logic            in_stall,
  input  logic [ChanW-1:0] in_red,
  input  logic [ChanW-1:0] in_green,
  input  logic [ChanW-1:0] in_blue,

  output logic            out_valid,
  input  logic            out_stall,
  output logic [OutW-1:0] out_hue,
  output logic [OutW-1:0] out_saturation,
  output logic [OutW-1:0] out_lightness
);

  // Stage 1: min/max
  logic mm_v_r;
  mm_t  mm_r;
  mm_t  mm_nxt;

  // Stage 2 is div_r[0]; quotient stages are div_r[1..DivStages].
  logic [DivStages:0] div_v_r;
  div_t               div_r   [DivStages+1];
  div_t               div_nxt [DivStages+1];

  // Load enables: a stage loads when it is empty or its successor loads.
  logic [DivStages:0] div_en;
  logic               mm_en;

  always_comb begin
    div_en[DivStages] = !div_v_r[DivStages] || !out_stall;
    for (int i = DivStages - 1; i >= 0; i--) begin
      div_en[i] = !div_v_r[i] || div_en[i+1];
    end
    mm_en = !mm_v_r || div_en[0];
  end

  assign in_stall = !mm_en;

  // ---- Stage 1: max, min, winning channel, chroma, sum --------------------
  always_comb begin
    logic [ChanW-1:0] hi;
    logic [ChanW-1:0] lo;
    hi = in_red;
    lo = in_red;
    // Red wins ties, then green.
    mm_nxt.sector = SECT_RED;
    if (in_green > hi) begin
      hi            = in_green;
      mm_nxt.sector = SECT_GREEN;
    end
    if (in_blue > hi) begin
      hi            = in_blue;
      mm_nxt.sector = SECT_BLUE;
    end
    if (in_green < lo) lo = in_green;
    if (in_blue < lo)  lo = in_blue;
    mm_nxt.red    = in_red;
    mm_nxt.green  = in_green;
    mm_nxt.blue   = in_blue;
    mm_nxt.chroma = hi - lo;
    mm_nxt.sum    = {1'b0, hi} + {1'b0, lo};
  end

  // ---- Stage 2: hue numerator and divisor, saturation dividend and divisor, lightness
  always_comb begin
    logic [NumW-1:0]      kc;
    logic [NumW-1:0]      pos;
    logic [NumW-1:0]      neg;
    logic signed [NumW-1:0] num;
    logic [HueDivW-1:0]   six_c;
    logic [SumW-1:0]      den;
    logic [OutW+ChanW-1:0] sat_x;
    logic [OutW:0]        light_x;

    six_c = {1'b0, mm_r.chroma, 2'b00} + {2'b00, mm_r.chroma, 1'b0};

    case (mm_r.sector)
      SECT_RED: begin
        kc  = '0;
        pos = NumW'(mm_r.green);
        neg = NumW'(mm_r.blue);
      end
      SECT_GREEN: begin
        kc  = NumW'({mm_r.chroma, 1'b0});
        pos = NumW'(mm_r.blue);
        neg = NumW'(mm_r.red);
      end
      SECT_BLUE: begin
        kc  = NumW'({mm_r.chroma, 2'b00});
        pos = NumW'(mm_r.red);
        neg = NumW'(mm_r.green);
      end
      default: begin
        kc  = '0;
        pos = '0;
        neg = '0;
      end
    endcase

    num = $signed(kc + pos - neg);
    // Wrap a negative hue by one turn.
    if (num < 0) num = num + $signed(NumW'(six_c));

    div_nxt[0].hue_rem = num[HueDivW-1:0];
    // Grey pixel: numerator is zero, keep the divisor nonzero.
    div_nxt[0].hue_div = (mm_r.chroma == '0) ? HueDivW'(1) : six_c;
    div_nxt[0].hue_q   = '0;

    // Denominator min(sum, 510 - sum); zero only for black or white.
    den = (mm_r.sum <= SumW'(255)) ? mm_r.sum : (SumW'(510) - mm_r.sum);
    div_nxt[0].sat_div = (den == '0) ? SatDivW'(1) : den[SatDivW-1:0];

    // chroma * 65535; its upper byte is below the divisor since chroma <= den.
    sat_x = {mm_r.chroma, {OutW{1'b0}}} - (OutW+ChanW)'(mm_r.chroma);
    div_nxt[0].sat_rem = sat_x[OutW+ChanW-1:OutW];
    div_nxt[0].sat_low = sat_x[OutW-1:0];
    div_nxt[0].sat_q   = '0;

    // (sum * 257) / 2
    light_x = {mm_r.sum, {ChanW{1'b0}}} + (OutW+1)'(mm_r.sum);
    div_nxt[0].light = light_x[OutW:1];

    for (int i = 1; i <= DivStages; i++) begin
      div_nxt[i] = div_step(div_r[i-1]);
    end
  end

  // ---- Valid bits ----------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mm_v_r  <= 1'b0;
      div_v_r <= '0;
    end else begin
      if (mm_en) mm_v_r <= in_valid;
      if (div_en[0]) div_v_r[0] <= mm_v_r;
      for (int i = 1; i <= DivStages; i++) begin
        if (div_en[i]) div_v_r[i] <= div_v_r[i-1];
      end
    end
  end

  // ---- Payload: advance with the load enables, hold otherwise -------------
  always_ff @(posedge clk) begin
    if (mm_en) mm_r <= mm_nxt;
    for (int i = 0; i <= DivStages; i++) begin
      if (div_en[i]) div_r[i] <= div_nxt[i];
    end
  end

  assign out_valid      = div_v_r[DivStages];
  assign out_hue        = div_r[DivStages].hue_q;
  assign out_saturation = div_r[DivStages].sat_q;
  assign out_lightness  = div_r[DivStages].light;

endmodule
